FILE: rtl/ist_pkg.sv
package ist_pkg;

	// Default table depth; the top level takes it as its CAPACITY parameter.
	localparam int CAPACITY_DEF = 64;

	// Fixed field widths of the stream payloads.
	localparam int VALUE_W = 32;
	localparam int COUNT_OUT_W = 7;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TEST   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// A request as it travels from cell to cell along the chain.
	typedef struct packed {
		logic                      vld;
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
		logic                      found;
	} token_t;

endpackage

FILE: rtl/ist_cell.sv
module ist_cell
	import ist_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  token_t                    tok_in,
	input  logic signed [VALUE_W-1:0] nxt_entry,
	input  logic [CW-1:0]             count,
	output logic signed [VALUE_W-1:0] entry,
	output token_t                    tok_out
);

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic signed [VALUE_W-1:0] entry_q;
	logic                      tok_vld_q;
	op_t                       tok_op_q;
	logic signed [VALUE_W-1:0] tok_value_q;
	logic                      tok_found_q;

	logic occupied;
	logic at_tail;
	logic match;
	logic do_shift;
	logic do_insert;

	// This cell holds a live entry only while its place is below the count.
	assign occupied  = (MY_IDX < count);
	assign at_tail   = (MY_IDX == count);
	assign match     = occupied && (entry_q == tok_in.value);
	assign do_shift  = tok_in.vld && (tok_in.op == OP_REMOVE) && occupied
		&& (tok_in.found || match);
	assign do_insert = tok_in.vld && (tok_in.op == OP_ADD) && at_tail && !tok_in.found;

	// Entry storage: removal pulls the successor in, an add lands at the tail.
	always_ff @(posedge clk) begin
		if (do_shift) begin
			entry_q <= nxt_entry;
		end else if (do_insert) begin
			entry_q <= tok_in.value;
		end
	end

	// Hand the request on to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_op_q    <= tok_in.op;
		tok_value_q <= tok_in.value;
		tok_found_q <= tok_in.found || match;
	end

	assign entry         = entry_q;
	assign tok_out.vld   = tok_vld_q;
	assign tok_out.op    = tok_op_q;
	assign tok_out.value = tok_value_q;
	assign tok_out.found = tok_found_q;

endmodule

FILE: rtl/integer_set_table.sv
// Table of up to CAPACITY distinct signed 32-bit integers kept in insertion
// order, built as a row of entry cells. Each transaction on the input stream
// carries an operation in tuser (add, remove, test or clear) and a value in
// tdata, and produces exactly one result transaction reporting hit, status,
// the entry count after the operation and an empty flag. A request walks the
// cell row one cell per cycle, and its result forms as it leaves the last cell;
// a new request is taken only once that result has left the row, so the row
// holds one request at a time. A finished
// result waits in the output register, backed by one spare result slot, so
// the next request may enter while an earlier result has not been taken.
module integer_set_table
	import ist_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value
	input  logic [1:0]  s_axis_tuser,  // [1:0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [0] hit, [2:1] status, [9:3] entry_count,
	                                   // [10] is_empty, [15:11] zero
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	token_t                    tok [0:CAPACITY];
	logic signed [VALUE_W-1:0] ent [0:CAPACITY-1];

	logic          busy_q;
	logic [CW-1:0] count_q;
	logic          out_vld_q;
	logic [10:0]   out_q;
	logic          pend_vld_q;
	logic [10:0]   pend_q;

	logic                      accept;
	logic                      fin;
	logic                      take;
	logic                      res_hit;
	status_t                   res_status;
	logic [CW-1:0]             cnt_new;
	logic [CW+COUNT_OUT_W-1:0] cnt_ext;
	logic [10:0]               res;

	assign s_axis_tready = !busy_q && !pend_vld_q;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// The accepted request enters the first cell directly.
	assign tok[0].vld   = accept;
	assign tok[0].op    = op_t'(s_axis_tuser);
	assign tok[0].value = s_axis_tdata;
	assign tok[0].found = 1'b0;

	// Row of entry cells; the last cell has no successor and keeps its own entry.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] nxt;
		if (i == CAPACITY - 1) begin : g_last
			assign nxt = ent[i];
		end else begin : g_mid
			assign nxt = ent[i+1];
		end
		ist_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.tok_in    (tok[i]),
			.nxt_entry (nxt),
			.count     (count_q),
			.entry     (ent[i]),
			.tok_out   (tok[i+1])
		);
	end

	assign fin  = tok[CAPACITY].vld;
	assign take = m_axis_tvalid && m_axis_tready;

	// Result of the request leaving the end of the row.
	always_comb begin
		res_hit    = 1'b0;
		res_status = ST_DONE;
		cnt_new    = count_q;
		case (tok[CAPACITY].op)
			OP_ADD: begin
				if (tok[CAPACITY].found) begin
					res_status = ST_MISS;
				end else if (count_q >= CAP_CNT) begin
					res_status = ST_FULL;
				end else begin
					res_hit = 1'b1;
					cnt_new = count_q + CW'(1);
				end
			end
			OP_REMOVE: begin
				if (tok[CAPACITY].found) begin
					res_hit = 1'b1;
					cnt_new = count_q - CW'(1);
				end else begin
					res_status = ST_MISS;
				end
			end
			OP_TEST: begin
				if (tok[CAPACITY].found) begin
					res_hit = 1'b1;
				end else begin
					res_status = ST_MISS;
				end
			end
			default: begin
				cnt_new = '0;
			end
		endcase
	end

	assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_new};
	assign res     = {(cnt_new == '0), cnt_ext[COUNT_OUT_W-1:0], res_status, res_hit};

	// Request tracking and the entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (fin) begin
				count_q <= cnt_new;
			end
		end
	end

	// Output register with one spare slot behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || take) begin
				if (pend_vld_q) begin
					out_vld_q  <= 1'b1;
					pend_vld_q <= fin;
				end else begin
					out_vld_q <= fin;
				end
			end else if (fin) begin
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			if (pend_vld_q) begin
				out_q <= pend_q;
				if (fin) begin
					pend_q <= res;
				end
			end else if (fin) begin
				out_q <= res;
			end
		end else if (fin) begin
			pend_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'b0, out_q};

endmodule
